// ===== hdl/dio_pkg.sv =====
// ============================================================================
// dio_pkg
// Shared types, register indexes, mode codes and reset values for the
// debounced I/O block with remote output override.
// ============================================================================
package dio_pkg;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_MODES  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_MODES = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_COUNT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_COUNT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCK_LIMIT   = 3'd4;

    // Register reset values
    localparam logic [8:0]  RST_INPUT_MODES  = 9'd146;
    localparam logic [8:0]  RST_OUTPUT_MODES = 9'd146;
    localparam logic [15:0] RST_SLOW_COUNT   = 16'd10000;
    localparam logic [15:0] RST_FAST_COUNT   = 16'd50;
    localparam logic [15:0] RST_LOCK_LIMIT   = 16'd5112;

    // Default debounce counter width
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // Channel mode codes (input and output)
    localparam logic [2:0] MODE_SAMPLE = 3'd2;  // input: sample pin
    localparam logic [2:0] MODE_FOLLOW = 3'd2;  // output: pin follows byte
    localparam logic [2:0] MODE_FREEZE = 3'd3;
    localparam logic [2:0] MODE_ON     = 3'd4;
    localparam logic [2:0] MODE_OFF    = 3'd5;

    // Output byte bit that is time limited under override
    localparam int unsigned LOCK_BIT = 6;
    // First output byte bit that drives a pin
    localparam int unsigned DRIVE_BASE = 5;

    typedef struct packed {
        logic [8:0]  input_modes;
        logic [8:0]  output_modes;
        logic [15:0] slow_count;
        logic [15:0] fast_count;
        logic [15:0] lock_limit_ms;
    } cfg_t;

    // One input beat
    typedef struct packed {
        logic [31:0] now_ms;
        logic [2:0]  pin_levels;
        logic        app_write;
        logic [7:0]  app_value;
        logic        remote_request;
        logic [7:0]  remote_value;
    } item_t;

endpackage

// ===== hdl/debounced_io_with_remote_override.sv =====
// ============================================================================
// debounced_io_with_remote_override
// Debounced digital inputs with a remotely overridable output byte.
// ============================================================================
// Usage:
//   Each input beat on s_* is one service tick: it carries the millisecond
//   time, raw active-low pin levels, an optional application write of the
//   output byte and the remote override request. Every tick yields exactly
//   one result beat on m_* with the debounced inputs, the output byte, the
//   three pin drive levels and the override flag.
//   A beat accepted on s_* is registered, processed once the result slot
//   is free, and its result is then valid on m_*. Throughput: one beat
//   per cycle unless m_ready stalls. The input register is refilled while the
//   result waits, so a stalled m_ready holds at most one beat in each stage;
//   s_ready drops only when both are full and the result is not taken.
//   The tick state registers double as the result register, so they advance
//   only when the previous result has gone.
//   Configuration: cfg_valid/cfg_index/cfg_data write one register per beat,
//   cfg_ready is always high; write only while no tick is in flight.
//   Reset (aresetn low, synchronous): registers take their default values,
//   all tick state clears, no beats are held.
// ============================================================================
module debounced_io_with_remote_override
    import dio_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input ticks
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [31:0]            s_now_ms,
    input  logic [2:0]             s_pin_levels,
    input  logic                   s_app_write,
    input  logic [7:0]             s_app_value,
    input  logic                   s_remote_request,
    input  logic [7:0]             s_remote_value,
    // results
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_debounced_inputs,
    output logic [7:0]             m_output_byte,
    output logic [2:0]             m_drive_pins,
    output logic                   m_override_active
);

    cfg_t  cfg;
    item_t item_reg;
    logic  in_valid_reg;
    logic  m_valid_reg;
    logic  advance;

    // Tick is processed when the result slot is free or being emptied
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.now_ms         <= s_now_ms;
            item_reg.pin_levels     <= s_pin_levels;
            item_reg.app_write      <= s_app_write;
            item_reg.app_value      <= s_app_value;
            item_reg.remote_request <= s_remote_request;
            item_reg.remote_value   <= s_remote_value;
        end
    end

    // Result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    dio_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dio_debounce #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_debounce (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .cfg        (cfg),
        .pin_levels (item_reg.pin_levels),
        .debounced  (m_debounced_inputs)
    );

    dio_override u_override (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (advance),
        .cfg             (cfg),
        .item            (item_reg),
        .output_byte     (m_output_byte),
        .drive_pins      (m_drive_pins),
        .override_active (m_override_active)
    );

    // A held tick is never dropped while waiting for the result slot
    a_in_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending tick lost");

    // Every processed tick shows up as a result
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("processed tick produced no result");

endmodule

// ===== hdl/dio_cfg.sv =====
// ============================================================================
// dio_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ============================================================================
module dio_cfg
    import dio_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.input_modes   <= RST_INPUT_MODES;
            cfg_reg.output_modes  <= RST_OUTPUT_MODES;
            cfg_reg.slow_count    <= RST_SLOW_COUNT;
            cfg_reg.fast_count    <= RST_FAST_COUNT;
            cfg_reg.lock_limit_ms <= RST_LOCK_LIMIT;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_INPUT_MODES:  cfg_reg.input_modes   <= cfg_data[8:0];
                REG_OUTPUT_MODES: cfg_reg.output_modes  <= cfg_data[8:0];
                REG_SLOW_COUNT:   cfg_reg.slow_count    <= cfg_data;
                REG_FAST_COUNT:   cfg_reg.fast_count    <= cfg_data;
                REG_LOCK_LIMIT:   cfg_reg.lock_limit_ms <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/dio_debounce.sv =====
// ============================================================================
// dio_debounce
// Samples three active-low input pins and debounces each channel with a
// saturating per-channel counter. State advances only on enable.
// ============================================================================
module dio_debounce
    import dio_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  cfg_t       cfg,
    input  logic [2:0] pin_levels,
    output logic [2:0] debounced
);

    localparam int unsigned CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [2:0]             sampled_reg, sampled_next;
    logic [2:0]             debounced_reg, debounced_next;
    logic [COUNT_WIDTH-1:0] cnt_reg [3];
    logic [COUNT_WIDTH-1:0] cnt_next [3];

    // Per-channel sample, force and debounce
    always_comb begin
        logic [2:0]             mode;
        logic [15:0]            limit;
        logic [COUNT_WIDTH-1:0] cnt_inc;
        sampled_next   = sampled_reg;
        debounced_next = debounced_reg;
        for (int ch = 0; ch < 3; ch++) begin
            mode        = cfg.input_modes[3*ch +: 3];
            limit       = (ch == 2) ? cfg.fast_count : cfg.slow_count;
            cnt_next[ch] = cnt_reg[ch];
            cnt_inc     = (cnt_reg[ch] == CNT_MAX) ? cnt_reg[ch]
                                                   : cnt_reg[ch] + 1'b1;
            if (mode == MODE_SAMPLE) begin
                sampled_next[ch] = ~pin_levels[ch];
            end
            if (mode == MODE_OFF) begin
                sampled_next[ch] = 1'b0;
            end else if (mode == MODE_ON) begin
                sampled_next[ch] = 1'b1;
            end else if (mode == MODE_FREEZE) begin
                // channel held
            end else if (sampled_next[ch] != debounced_reg[ch]) begin
                if (CMP_W'(cnt_inc) >= CMP_W'(limit)) begin
                    cnt_next[ch]       = '0;
                    debounced_next[ch] = sampled_next[ch];
                end else begin
                    cnt_next[ch] = cnt_inc;
                end
            end else begin
                cnt_next[ch] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sampled_reg   <= '0;
            debounced_reg <= '0;
            for (int ch = 0; ch < 3; ch++) begin
                cnt_reg[ch] <= '0;
            end
        end else if (en) begin
            sampled_reg   <= sampled_next;
            debounced_reg <= debounced_next;
            for (int ch = 0; ch < 3; ch++) begin
                cnt_reg[ch] <= cnt_next[ch];
            end
        end
    end

    assign debounced = debounced_reg;

    // Debounced state moves only on a processed beat
    a_deb_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(debounced_reg))
        else $error("debounced state changed without a beat");

endmodule

// ===== hdl/dio_override.sv =====
// ============================================================================
// dio_override
// Output byte path: application write, remote override with save/restore
// and bit-6 time lock, then per-bit output modes driving three pins.
// ============================================================================
module dio_override
    import dio_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  cfg_t       cfg,
    input  item_t      item,
    output logic [7:0] output_byte,
    output logic [2:0] drive_pins,
    output logic       override_active
);

    logic [7:0]  out_reg, out_next;
    logic [7:0]  saved_reg, saved_next;
    logic        ovr_reg, ovr_next;
    logic        lock_timing_reg, lock_timing_next;
    logic [31:0] lock_start_reg, lock_start_next;
    logic [2:0]  drive_reg, drive_next;
    logic [31:0] elapsed;

    assign elapsed = item.now_ms - lock_start_reg;

    // Byte update for one tick
    always_comb begin
        logic [2:0] mode;
        out_next         = item.app_write ? item.app_value : out_reg;
        saved_next       = saved_reg;
        ovr_next         = ovr_reg;
        lock_timing_next = lock_timing_reg;
        lock_start_next  = lock_start_reg;
        drive_next       = drive_reg;

        // remote override
        if (item.remote_request) begin
            if (!ovr_reg) begin
                saved_next = out_next;
                ovr_next   = 1'b1;
            end
            out_next = item.remote_value;
            if (item.remote_value[LOCK_BIT] && !lock_timing_reg) begin
                lock_timing_next = 1'b1;
                lock_start_next  = item.now_ms;
            end else if (!item.remote_value[LOCK_BIT]) begin
                lock_timing_next = 1'b0;
            end else if (elapsed >= {16'd0, cfg.lock_limit_ms}) begin
                out_next[LOCK_BIT] = 1'b0;
            end
        end else if (ovr_reg) begin
            out_next         = saved_reg;
            ovr_next         = 1'b0;
            lock_timing_next = 1'b0;
        end

        // output modes on bits 5..7
        for (int k = 0; k < 3; k++) begin
            mode = cfg.output_modes[3*k +: 3];
            case (mode)
                MODE_OFF: begin
                    out_next[DRIVE_BASE+k] = 1'b0;
                    drive_next[k]          = 1'b0;
                end
                MODE_ON: begin
                    out_next[DRIVE_BASE+k] = 1'b1;
                    drive_next[k]          = 1'b1;
                end
                MODE_FOLLOW: begin
                    drive_next[k] = out_next[DRIVE_BASE+k];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg         <= '0;
            saved_reg       <= '0;
            ovr_reg         <= 1'b0;
            lock_timing_reg <= 1'b0;
            lock_start_reg  <= '0;
            drive_reg       <= '0;
        end else if (en) begin
            out_reg         <= out_next;
            saved_reg       <= saved_next;
            ovr_reg         <= ovr_next;
            lock_timing_reg <= lock_timing_next;
            lock_start_reg  <= lock_start_next;
            drive_reg       <= drive_next;
        end
    end

    assign output_byte     = out_reg;
    assign drive_pins      = drive_reg;
    assign override_active = ovr_reg;

    // Override follows the request of the processed beat
    a_ovr_set: assert property (@(posedge aclk) disable iff (!aresetn)
        en && item.remote_request |=> ovr_reg)
        else $error("override not latched on request");

    a_ovr_end: assert property (@(posedge aclk) disable iff (!aresetn)
        en && !item.remote_request |=> !ovr_reg && !lock_timing_reg)
        else $error("override or lock timer survived end of request");

endmodule

// ===== verif/tb_debounced_io_with_remote_override.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_debounced_io_with_remote_override
// Self-checking bench for the debounced I/O block. Drives service ticks on
// s_*, predicts each tick's result from an in-bench copy of the tick state,
// and compares every m_* beat against the oldest prediction. Directed tests
// cover modes, limits and override corners; a random phase sweep follows.
// ============================================================================
module tb_debounced_io_with_remote_override;
    import dio_pkg::*;

    // Mode codes that have no meaning to the block (held / ignored)
    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_OTHER_HI = 3'd7;
    localparam int         STALL_LIMIT   = 1000;

    typedef struct packed {
        logic [2:0] dbn;
        logic [7:0] obyte;
        logic [2:0] drv;
        logic       ovr;
    } io_snapshot_t;

    logic                   aclk             = 1'b0;
    logic                   aresetn          = 1'b0;
    logic                   cfg_valid        = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index        = '0;
    logic [CFG_DATA_W-1:0]  cfg_data         = '0;
    logic                   s_valid          = 1'b0;
    logic                   s_ready;
    logic [31:0]            s_now_ms         = '0;
    logic [2:0]             s_pin_levels     = '0;
    logic                   s_app_write      = 1'b0;
    logic [7:0]             s_app_value      = '0;
    logic                   s_remote_request = 1'b0;
    logic [7:0]             s_remote_value   = '0;
    logic                   m_valid;
    logic                   m_ready          = 1'b0;
    logic [2:0]             m_debounced_inputs;
    logic [7:0]             m_output_byte;
    logic [2:0]             m_drive_pins;
    logic                   m_override_active;

    debounced_io_with_remote_override dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_now_ms           (s_now_ms),
        .s_pin_levels       (s_pin_levels),
        .s_app_write        (s_app_write),
        .s_app_value        (s_app_value),
        .s_remote_request   (s_remote_request),
        .s_remote_value     (s_remote_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_debounced_inputs (m_debounced_inputs),
        .m_output_byte      (m_output_byte),
        .m_drive_pins       (m_drive_pins),
        .m_override_active  (m_override_active)
    );

    // Clock, 10 ns
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Bench copy of registers and tick state
    logic [8:0]   in_modes, out_modes;
    logic [15:0]  slow_lim, fast_lim, lock_ms;
    logic [2:0]   smp_bits, dbn_bits, drv_pins;
    logic [15:0]  dbn_cnt [3];
    logic [7:0]   out_reg, saved_byte;
    logic         ovr_on, lock_run;
    logic [31:0]  lock_t0;

    io_snapshot_t io_snapshots_due [$];
    int           mismatches  = 0;
    int           stall_cycles = 0;
    bit           gaps_on     = 1'b1;

    // Random traffic state
    logic [31:0]  clock_ms   = '0;
    logic [2:0]   held_pins  = 3'b111;
    int           ovr_left   = 0;
    logic [7:0]   ovr_byte   = '0;

    task automatic reset_state();
        in_modes   = RST_INPUT_MODES;
        out_modes  = RST_OUTPUT_MODES;
        slow_lim   = RST_SLOW_COUNT;
        fast_lim   = RST_FAST_COUNT;
        lock_ms    = RST_LOCK_LIMIT;
        smp_bits   = '0;
        dbn_bits   = '0;
        drv_pins   = '0;
        out_reg    = '0;
        saved_byte = '0;
        ovr_on     = 1'b0;
        lock_run   = 1'b0;
        lock_t0    = '0;
        for (int ch = 0; ch < 3; ch++) dbn_cnt[ch] = '0;
    endtask

    task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_INPUT_MODES:  in_modes  = data[8:0];
            REG_OUTPUT_MODES: out_modes = data[8:0];
            REG_SLOW_COUNT:   slow_lim  = data;
            REG_FAST_COUNT:   fast_lim  = data;
            REG_LOCK_LIMIT:   lock_ms   = data;
            default: ;
        endcase
    endtask

    // One channel of the debounce filter; forced/frozen channels hold count
    task automatic filter_channel(input int ch, input logic [15:0] lim);
        logic [2:0] md;
        md = in_modes[3*ch +: 3];
        if (md == MODE_OFF) begin
            smp_bits[ch] = 1'b0;
        end else if (md == MODE_ON) begin
            smp_bits[ch] = 1'b1;
        end else if (md == MODE_FREEZE) begin
            // held
        end else if (smp_bits[ch] != dbn_bits[ch]) begin
            if (dbn_cnt[ch] != '1) dbn_cnt[ch] = dbn_cnt[ch] + 16'd1;
            if (dbn_cnt[ch] >= lim) begin
                dbn_cnt[ch]  = '0;
                dbn_bits[ch] = smp_bits[ch];
            end
        end else begin
            dbn_cnt[ch] = '0;
        end
    endtask

    // Advance the bench state by one tick and queue the resulting snapshot
    task automatic service_tick(input item_t it);
        io_snapshot_t snap;
        logic [2:0]   md;
        logic [31:0]  elapsed;
        if (it.app_write) out_reg = it.app_value;

        // sample active-low pins
        for (int ch = 0; ch < 3; ch++)
            if (in_modes[3*ch +: 3] == MODE_SAMPLE) smp_bits[ch] = ~it.pin_levels[ch];
        filter_channel(0, slow_lim);
        filter_channel(1, slow_lim);
        filter_channel(2, fast_lim);

        // remote override with time-limited lock bit
        elapsed = it.now_ms - lock_t0;
        if (it.remote_request) begin
            if (!ovr_on) begin
                saved_byte = out_reg;
                ovr_on     = 1'b1;
            end
            out_reg = it.remote_value;
            if (it.remote_value[LOCK_BIT] && !lock_run) begin
                lock_run = 1'b1;
                lock_t0  = it.now_ms;
            end else if (!it.remote_value[LOCK_BIT]) begin
                lock_run = 1'b0;
            end else if (elapsed >= {16'h0, lock_ms}) begin
                out_reg[LOCK_BIT] = 1'b0;
            end
        end else if (ovr_on) begin
            out_reg  = saved_byte;
            ovr_on   = 1'b0;
            lock_run = 1'b0;
        end

        // output modes
        for (int k = 0; k < 3; k++) begin
            md = out_modes[3*k +: 3];
            if (md == MODE_OFF) begin
                out_reg[DRIVE_BASE+k] = 1'b0;
                drv_pins[k]           = 1'b0;
            end else if (md == MODE_ON) begin
                out_reg[DRIVE_BASE+k] = 1'b1;
                drv_pins[k]           = 1'b1;
            end else if (md == MODE_FOLLOW) begin
                drv_pins[k] = out_reg[DRIVE_BASE+k];
            end
        end

        snap.dbn   = dbn_bits;
        snap.obyte = out_reg;
        snap.drv   = drv_pins;
        snap.ovr   = ovr_on;
        io_snapshots_due.push_back(snap);
    endtask

    // Send one tick; returns in the step of the accepting edge
    task automatic send_tick(input item_t it);
        while (gaps_on && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_now_ms         <= it.now_ms;
        s_pin_levels     <= it.pin_levels;
        s_app_write      <= it.app_write;
        s_app_value      <= it.app_value;
        s_remote_request <= it.remote_request;
        s_remote_value   <= it.remote_value;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        service_tick(it);
    endtask

    // Stop sending and wait until every predicted beat has come back
    task automatic settle();
        s_valid <= 1'b0;
        while (io_snapshots_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic item_t mk_tick(logic [31:0] now, logic [2:0] pins, logic aw,
                                      logic [7:0] av, logic rr, logic [7:0] rv);
        item_t it;
        it.now_ms         = now;
        it.pin_levels     = pins;
        it.app_write      = aw;
        it.app_value      = av;
        it.remote_request = rr;
        it.remote_value   = rv;
        return it;
    endfunction

    function automatic logic [8:0] modes3(logic [2:0] c0, logic [2:0] c1, logic [2:0] c2);
        return {c2, c1, c0};
    endfunction

    function automatic logic [2:0] pick_mode(logic [2:0] usual);
        if ($urandom_range(99) < 75) return usual;
        return 3'($urandom_range(0, 7));
    endfunction

    // Random tick: advancing time, bouncing pins, override episodes, some noise
    task automatic next_tick(output item_t it);
        if ($urandom_range(99) < 2) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 25);
        if ($urandom_range(99) < 25) held_pins = 3'($urandom_range(0, 7));
        if (ovr_left == 0 && $urandom_range(99) < 8) begin
            ovr_left           = $urandom_range(1, 40);
            ovr_byte           = 8'($urandom_range(0, 255));
            ovr_byte[LOCK_BIT] = ($urandom_range(99) < 70);
        end else if (ovr_left != 0 && $urandom_range(99) < 5) begin
            ovr_byte = 8'($urandom_range(0, 255));
        end
        it.now_ms         = clock_ms;
        it.pin_levels     = held_pins;
        it.app_write      = ($urandom_range(99) < 20);
        it.app_value      = 8'($urandom_range(0, 255));
        it.remote_request = (ovr_left != 0);
        it.remote_value   = (ovr_left != 0) ? ovr_byte : 8'($urandom_range(0, 255));
        if ($urandom_range(99) < 3) it.remote_request = ~it.remote_request;
        if (ovr_left != 0) ovr_left--;
    endtask

    task automatic send_random(input int n);
        item_t it;
        repeat (n) begin
            next_tick(it);
            send_tick(it);
        end
    endtask

    // Result beats: compare against oldest prediction
    task automatic compare_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            mismatches++;
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, got_v);
        end
    endtask

    always @(negedge aclk) begin
        io_snapshot_t exp_snap;
        if (aresetn && m_valid && m_ready) begin
            if (io_snapshots_due.size() == 0) begin
                mismatches++;
                $error("result beat with no tick outstanding");
            end else begin
                exp_snap = io_snapshots_due.pop_front();
                compare_field("debounced_inputs", exp_snap.dbn, m_debounced_inputs);
                compare_field("output_byte", exp_snap.obyte, m_output_byte);
                compare_field("drive_pins", exp_snap.drv, m_drive_pins);
                compare_field("override_active", exp_snap.ovr, m_override_active);
            end
        end
        // watchdog: cycles with no beat on any channel
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        m_ready <= !gaps_on || ($urandom_range(99) >= 8);
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, zero/one debounce limits, override corners, lock expiry
    task automatic test_directed_corners();
        settle();
        write_reg(REG_SLOW_COUNT, 16'd1);
        write_reg(REG_FAST_COUNT, 16'd0);
        send_tick(mk_tick(32'h0, 3'b000, 1'b0, 8'h00, 1'b0, 8'h00));
        send_tick(mk_tick(32'h1, 3'b111, 1'b1, 8'hFF, 1'b0, 8'h00));
        send_tick(mk_tick(32'h2, 3'b010, 1'b1, 8'h00, 1'b0, 8'h00));
        send_tick(mk_tick(32'h3, 3'b101, 1'b1, 8'hFF, 1'b0, 8'h00));
        // override starts at the top of the time range, timer wraps
        send_tick(mk_tick(32'hFFFF_FFFF, 3'b111, 1'b1, 8'hFF, 1'b1, 8'hFF));
        send_tick(mk_tick(32'h0, 3'b000, 1'b1, 8'h00, 1'b1, 8'hFF));
        send_tick(mk_tick(32'd5110, 3'b000, 1'b0, 8'h00, 1'b1, 8'hFF));
        send_tick(mk_tick(32'd5111, 3'b000, 1'b0, 8'h00, 1'b1, 8'hFF));
        send_tick(mk_tick(32'd5112, 3'b000, 1'b0, 8'h00, 1'b1, 8'hFF));
        // lock bit dropped, then re-raised: timer restarts
        send_tick(mk_tick(32'd5113, 3'b111, 1'b0, 8'h00, 1'b1, 8'h3F));
        send_tick(mk_tick(32'd5114, 3'b111, 1'b0, 8'h00, 1'b1, 8'hC0));
        // end of override restores saved byte
        send_tick(mk_tick(32'd5115, 3'b111, 1'b0, 8'h00, 1'b0, 8'hFF));
        send_tick(mk_tick(32'd5116, 3'b111, 1'b1, 8'h5A, 1'b0, 8'h00));
        // app write and override start in one tick
        send_tick(mk_tick(32'd5117, 3'b000, 1'b1, 8'hA5, 1'b1, 8'h00));
        send_tick(mk_tick(32'd5118, 3'b000, 1'b0, 8'h00, 1'b0, 8'h00));
    endtask

    task automatic test_input_modes();
        settle();
        write_reg(REG_SLOW_COUNT, 16'd2);
        write_reg(REG_FAST_COUNT, 16'd1);
        write_reg(REG_INPUT_MODES, modes3(MODE_OFF, MODE_ON, MODE_FREEZE));
        send_random(8);
        settle();
        write_reg(REG_INPUT_MODES, modes3(MODE_IDLE, MODE_OTHER_HI, MODE_SAMPLE));
        send_random(8);
        settle();
        write_reg(REG_INPUT_MODES, modes3(MODE_ON, MODE_OFF, MODE_ON));
        send_random(4);
        settle();
        write_reg(REG_INPUT_MODES, modes3(3'd1, 3'd6, MODE_OFF));
        send_random(8);
        settle();
        write_reg(REG_INPUT_MODES, RST_INPUT_MODES);
        send_random(8);
    endtask

    task automatic test_output_modes();
        settle();
        write_reg(REG_LOCK_LIMIT, 16'd40);
        write_reg(REG_OUTPUT_MODES, modes3(MODE_ON, MODE_OFF, MODE_FOLLOW));
        send_random(12);
        settle();
        write_reg(REG_OUTPUT_MODES, modes3(MODE_FREEZE, MODE_IDLE, MODE_OTHER_HI));
        send_random(12);
        settle();
        write_reg(REG_OUTPUT_MODES, modes3(MODE_OFF, MODE_ON, MODE_OFF));
        send_random(12);
        settle();
        write_reg(REG_OUTPUT_MODES, RST_OUTPUT_MODES);
        send_random(8);
    endtask

    // Largest debounce limits never complete here; zero transfers at once
    task automatic test_count_extremes();
        settle();
        write_reg(REG_SLOW_COUNT, 16'hFFFF);
        write_reg(REG_FAST_COUNT, 16'hFFFF);
        send_random(30);
        settle();
        write_reg(REG_SLOW_COUNT, 16'd0);
        write_reg(REG_FAST_COUNT, 16'd0);
        send_random(20);
    endtask

    task automatic test_lock_extremes();
        logic [31:0] t;
        settle();
        write_reg(REG_LOCK_LIMIT, 16'd0);
        t = $urandom;
        send_tick(mk_tick(t,      3'b111, 1'b1, 8'h00, 1'b1, 8'hFF));
        send_tick(mk_tick(t,      3'b111, 1'b0, 8'h00, 1'b1, 8'hFF));
        send_tick(mk_tick(t + 1,  3'b111, 1'b0, 8'h00, 1'b1, 8'h40));
        send_tick(mk_tick(t + 2,  3'b111, 1'b0, 8'h00, 1'b0, 8'h00));
        settle();
        write_reg(REG_LOCK_LIMIT, 16'hFFFF);
        t = 32'hFFFF_8000;
        send_tick(mk_tick(t,            3'b000, 1'b0, 8'h00, 1'b1, 8'h7F));
        send_tick(mk_tick(t + 32'd65534, 3'b000, 1'b0, 8'h00, 1'b1, 8'h7F));
        send_tick(mk_tick(t + 32'd65535, 3'b000, 1'b0, 8'h00, 1'b1, 8'h7F));
        send_tick(mk_tick(t + 32'd65536, 3'b000, 1'b0, 8'h00, 1'b1, 8'h7F));
        send_tick(mk_tick(t + 32'd65537, 3'b000, 1'b1, 8'h11, 1'b0, 8'h00));
    endtask

    // Unused indexes are ignored; mode registers keep only their low bits
    task automatic test_register_decode();
        settle();
        for (int i = REG_LOCK_LIMIT + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), 16'($urandom_range(0, 65535)));
        write_reg(REG_INPUT_MODES, {7'($urandom_range(1, 127)), RST_INPUT_MODES});
        write_reg(REG_OUTPUT_MODES, {7'($urandom_range(1, 127)), modes3(MODE_FOLLOW,
                                     MODE_ON, MODE_FOLLOW)});
        write_reg(REG_SLOW_COUNT, 16'd3);
        write_reg(REG_FAST_COUNT, 16'd2);
        send_random(16);
    endtask

    // Phases of random traffic, each under a fresh random register set
    task automatic test_random_traffic();
        for (int ph = 0; ph < 10; ph++) begin
            settle();
            gaps_on = (ph != 0);
            if (ph == 3) clock_ms = 32'hFFFF_FFFF - 32'd400;
            else clock_ms = $urandom;
            write_reg(REG_INPUT_MODES, modes3(pick_mode(MODE_SAMPLE), pick_mode(MODE_SAMPLE),
                                              pick_mode(MODE_SAMPLE)));
            write_reg(REG_OUTPUT_MODES, modes3(pick_mode(MODE_FOLLOW), pick_mode(MODE_FOLLOW),
                                               pick_mode(MODE_FOLLOW)));
            write_reg(REG_SLOW_COUNT, ($urandom_range(99) < 90) ? 16'($urandom_range(0, 12))
                                                                 : 16'($urandom_range(0, 65535)));
            write_reg(REG_FAST_COUNT, ($urandom_range(99) < 90) ? 16'($urandom_range(0, 6))
                                                                 : 16'($urandom_range(0, 65535)));
            write_reg(REG_LOCK_LIMIT, ($urandom_range(99) < 80) ? 16'($urandom_range(0, 300))
                                                                 : 16'($urandom_range(0, 65535)));
            send_random(100);
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        reset_state();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_input_modes();
        test_output_modes();
        test_count_extremes();
        test_lock_extremes();
        test_register_decode();
        test_random_traffic();

        settle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && io_snapshots_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
